FILE: hw/rtl/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg
// Types, constants and codes shared by the stereo sample playback resampler.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int FRACTION_BITS   = 16;
  localparam int INDEX_BITS      = 12;
  localparam int POS_BITS        = INDEX_BITS + FRACTION_BITS;
  localparam int COUNT_BITS      = INDEX_BITS + 1;
  localparam int SPEED_BITS      = 24;
  localparam int CFG_DATA_BITS   = 24;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int FRAME_DEPTH_DEF = 4096;

  localparam logic [SPEED_BITS-1:0] SPEED_RESET       = SPEED_BITS'(65536);
  localparam logic [COUNT_BITS-1:0] FRAME_COUNT_RESET = COUNT_BITS'(4096);

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPEED       = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOPING     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ONE_SHOT    = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_COUNT = 2'd3;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_SET  = 2'd1;
  localparam logic [1:0] FUNC_PLAY = 2'd2;

  typedef struct packed {
    logic [1:0]                    func;
    logic [INDEX_BITS-1:0]         frame_addr;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic [POS_BITS-1:0]           new_position;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          ended;
    logic                          released;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic emit_imm;
    logic rd;
    logic sel_w;
    logic mod_start;
    logic mod_sel_adv;
    logic mod_pos_wr;
    logic mix;
    logic mod_adv_wr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic play;
    logic ended;
    logic need_mod;
    logic adv_mod;
    logic mod_done;
  } ctrl_status_t;

endpackage

FILE: hw/rtl/stereo_sample_playback_resampler.sv
// ----------------------------------------------------------------------------
// stereo_sample_playback_resampler
// Stereo sample playback voice with linear interpolation between frames.
// ----------------------------------------------------------------------------
// Load, set-position, unused and ended play words: result registered at accept,
// one word per cycle while the output is free. Play words: read of both frames
// at accept, then mix and advance from the registered read data; no new word is
// taken meanwhile. A looping position at or past the frame count is reduced first,
// an advance at or past it after the mix (13-step remainder unit).
// Synchronous reset: position 0, registers to defaults; sample memory kept.
module stereo_sample_playback_resampler
  import ssr_pkg::*;
#(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_word_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_word_t                 out_data,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  ctrl_cmd_t    cmd;
  ctrl_status_t st;

  ssr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  ssr_datapath #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_data  (in_data),
    .out_ready(out_ready),
    .cmd      (cmd),
    .st       (st),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  a_mix_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mix |-> !out_valid)
    else $error("interpolated word written while the output word is still held");

  a_play_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && st.play && !st.ended |=> !in_ready)
    else $error("new word accepted while a play word is in progress");

  a_mod_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_start |=> !st.mod_done)
    else $error("remainder unit reports done right after start");

endmodule

FILE: hw/rtl/ssr_ram.sv
// ----------------------------------------------------------------------------
// ssr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ssr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/ssr_mod.sv
// ----------------------------------------------------------------------------
// ssr_mod
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ssr_mod
  import ssr_pkg::*;
#(
  parameter int W = COUNT_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [CW-1:0] cnt_r;
  logic [W:0]    trial;
  logic          ge;

  assign trial = {rem_r, quo_r[W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? W'(trial - {1'b0, divisor}) : W'(trial);
      quo_r <= {quo_r[W-2:0], 1'b0};
    end
  end

  assign done = (cnt_r == '0);
  assign rem  = rem_r;

endmodule

FILE: hw/rtl/ssr_datapath.sv
// ----------------------------------------------------------------------------
// ssr_datapath
// Configuration, play position, sample memory, interpolation and result word.
// ----------------------------------------------------------------------------
module ssr_datapath
  import ssr_pkg::*;
#(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  input  in_word_t                  in_data,
  input  logic                      out_ready,
  input  ctrl_cmd_t                 cmd,
  output ctrl_status_t              st,
  output logic                      out_valid,
  output out_word_t                 out_data
);

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int SB = SAMPLE_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int AB = SB + FB + 3;
  localparam logic [AB-1:0] MIX_HALF = AB'(1) << (FB - 1);

  logic [SPEED_BITS-1:0] speed_r;
  logic                  looping_r;
  logic                  one_shot_r;
  logic [COUNT_BITS-1:0] frame_count_r;
  logic [COUNT_BITS-1:0] fc;

  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] w_pos_r, w_pos_nxt;
  logic [FB-1:0]       adv_frac_r;
  logic                release_done_r;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_data_r, out_data_nxt;

  logic [POS_BITS-1:0]   cur_pos;
  logic [COUNT_BITS-1:0] cur_idx, idx_inc, nxt_idx;
  logic [COUNT_BITS-1:0] pos_int;
  logic [POS_BITS:0]     np;
  logic [COUNT_BITS-1:0] np_int;
  logic [COUNT_BITS-1:0] mod_dividend, mod_rem;
  logic                  mod_done;
  logic                  ended_now, release_now;
  logic                  load_we;
  logic [2*SB-1:0]       rdata_a, rdata_b;

  function automatic logic [SB-1:0] mix(logic signed [SB-1:0] a, logic signed [SB-1:0] b,
                                        logic [FB-1:0] t);
    logic signed [SB:0]      diff;
    logic signed [SB+FB+1:0] prod;
    logic [AB-1:0]           acc;
    diff = $signed({b[SB-1], b}) - $signed({a[SB-1], a});
    prod = diff * $signed({1'b0, t});
    acc  = {{3{a[SB-1]}}, a, {FB{1'b0}}} + {prod[SB+FB+1], prod} + MIX_HALF;
    return acc[SB+FB-1:FB];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r       <= SPEED_RESET;
      looping_r     <= 1'b0;
      one_shot_r    <= 1'b0;
      frame_count_r <= FRAME_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED:       speed_r       <= cfg_wdata[SPEED_BITS-1:0];
        CFG_LOOPING:     looping_r     <= cfg_wdata[0];
        CFG_ONE_SHOT:    one_shot_r    <= cfg_wdata[0];
        CFG_FRAME_COUNT: frame_count_r <= cfg_wdata[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (frame_count_r == '0) begin
      fc = COUNT_BITS'(1);
    end else if (32'(frame_count_r) > FRAME_DEPTH) begin
      fc = COUNT_BITS'(FRAME_DEPTH);
    end else begin
      fc = frame_count_r;
    end
  end

  assign pos_int   = {1'b0, pos_r[POS_BITS-1:FB]};
  assign ended_now = !looping_r && ((pos_int + COUNT_BITS'(|pos_r[FB-1:0])) >= fc);
  assign release_now = st.play && ended_now && one_shot_r && !release_done_r;

  assign cur_pos = cmd.sel_w ? w_pos_r : pos_r;
  assign cur_idx = {1'b0, cur_pos[POS_BITS-1:FB]};
  assign idx_inc = cur_idx + 1'b1;
  assign nxt_idx = (idx_inc >= fc) ? '0 : idx_inc;

  assign np     = {1'b0, w_pos_r} + (POS_BITS + 1)'(speed_r);
  assign np_int = np[POS_BITS:FB];

  assign mod_dividend = cmd.mod_sel_adv ? np_int : pos_int;

  assign load_we = cmd.accept && (in_data.func == FUNC_LOAD) &&
                   (32'(in_data.frame_addr) < FRAME_DEPTH);

  ssr_ram #(
    .WIDTH(2 * SB),
    .DEPTH(FRAME_DEPTH)
  ) u_ram_a (
    .clk  (clk),
    .we   (load_we),
    .waddr(AW'(in_data.frame_addr)),
    .wdata({in_data.left_in, in_data.right_in}),
    .re   (cmd.rd),
    .raddr(AW'(cur_idx)),
    .rdata(rdata_a)
  );

  ssr_ram #(
    .WIDTH(2 * SB),
    .DEPTH(FRAME_DEPTH)
  ) u_ram_b (
    .clk  (clk),
    .we   (load_we),
    .waddr(AW'(in_data.frame_addr)),
    .wdata({in_data.left_in, in_data.right_in}),
    .re   (cmd.rd),
    .raddr(AW'(nxt_idx)),
    .rdata(rdata_b)
  );

  ssr_mod #(
    .W(COUNT_BITS)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mod_start),
    .dividend(mod_dividend),
    .divisor (fc),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.accept && (in_data.func == FUNC_SET)) begin
      pos_nxt = in_data.new_position;
    end else if (cmd.mix && !st.adv_mod) begin
      if (looping_r || !np[POS_BITS]) begin
        pos_nxt = np[POS_BITS-1:0];
      end else begin
        pos_nxt = '1;
      end
    end else if (cmd.mod_adv_wr) begin
      pos_nxt = {mod_rem[INDEX_BITS-1:0], adv_frac_r};
    end
  end

  always_comb begin
    w_pos_nxt = w_pos_r;
    if (cmd.accept) begin
      w_pos_nxt = pos_r;
    end else if (cmd.mod_pos_wr) begin
      w_pos_nxt = {mod_rem[INDEX_BITS-1:0], w_pos_r[FB-1:0]};
    end
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.emit_imm) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.left_out  = '0;
      out_data_nxt.right_out = '0;
      out_data_nxt.ended     = st.play && ended_now;
      out_data_nxt.released  = release_now;
    end else if (cmd.mix) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.left_out  = mix(rdata_a[2*SB-1:SB], rdata_b[2*SB-1:SB], w_pos_r[FB-1:0]);
      out_data_nxt.right_out = mix(rdata_a[SB-1:0], rdata_b[SB-1:0], w_pos_r[FB-1:0]);
      out_data_nxt.ended     = 1'b0;
      out_data_nxt.released  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r          <= '0;
      release_done_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.emit_imm && release_now) begin
        release_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_pos_r    <= w_pos_nxt;
    out_data_r <= out_data_nxt;
    if (cmd.mix) begin
      adv_frac_r <= np[FB-1:0];
    end
  end

  assign st.out_free = !out_valid_r || out_ready;
  assign st.play     = (in_data.func == FUNC_PLAY);
  assign st.ended    = ended_now;
  assign st.need_mod = looping_r && (pos_int >= fc);
  assign st.adv_mod  = looping_r && (np_int >= fc);
  assign st.mod_done = mod_done;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/ssr_ctrl.sv
// ----------------------------------------------------------------------------
// ssr_ctrl
// Sequencer: decode for each word; wrap, read, mix and advance for play words.
// ----------------------------------------------------------------------------
module ssr_ctrl
  import ssr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  ctrl_status_t st,
  output ctrl_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MODP = 5'b00010,
    S_RD   = 5'b00100,
    S_MIX  = 5'b01000,
    S_MODA = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) && st.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          if (!st.play || st.ended) begin
            cmd.emit_imm = 1'b1;
          end else if (st.need_mod) begin
            cmd.mod_start = 1'b1;
            state_nxt     = S_MODP;
          end else begin
            cmd.rd    = 1'b1;
            state_nxt = S_MIX;
          end
        end
      end
      S_MODP: begin
        if (st.mod_done) begin
          cmd.mod_pos_wr = 1'b1;
          state_nxt      = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        cmd.sel_w = 1'b1;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.mix = 1'b1;
        if (st.adv_mod) begin
          cmd.mod_start   = 1'b1;
          cmd.mod_sel_adv = 1'b1;
          state_nxt       = S_MODA;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MODA: begin
        if (st.mod_done) begin
          cmd.mod_adv_wr = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo sample playback resampler. A directed
// table covers reset values, extreme samples and positions, the unused
// function, wrap to frame 0, saturation and the end of playback. Random
// phases then run under several register settings. Every result word is
// checked in order against the table's typed result or a built-in voice
// predictor, while the sender bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_top
  import ssr_pkg::*;
();

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int FRAME_SLOTS = FRAME_DEPTH_DEF;
  localparam longint unsigned FIX_ONE = 64'd1 << FRACTION_BITS;
  localparam longint unsigned SAMPLE_BIAS = 64'd1 << (SAMPLE_BITS - 1);
  localparam longint unsigned POS_MAX = (64'd1 << POS_BITS) - 1;
  localparam int PHASES = 9;
  localparam int PHASE_WORDS = 100;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_AFTER = 250;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t result;
  } cue_t;

  localparam out_word_t QUIET = '0;
  localparam out_word_t ENDED = '{16'h0000, 16'h0000, 1'b1, 1'b0};

  localparam cue_t CUE_TABLE [19] = '{
    '{'{FUNC_LOAD, 12'h000, 16'h7FFF, 16'h8000, 28'h0000000}, 1'b1, QUIET},
    '{'{FUNC_LOAD, 12'h001, 16'h8000, 16'h7FFF, 28'h0000000}, 1'b1, QUIET},
    '{'{FUNC_LOAD, 12'hFFF, 16'hFFFF, 16'h0001, 28'h0000000}, 1'b1, QUIET},
    '{'{FUNC_UNUSED, 12'hFFF, 16'hFFFF, 16'hFFFF, 28'hFFFFFFF}, 1'b1, QUIET},
    '{'{FUNC_PLAY, 12'h000, 16'h0000, 16'h0000, 28'h0000000}, 1'b1,
      '{16'h7FFF, 16'h8000, 1'b0, 1'b0}},
    '{'{FUNC_SET, 12'h000, 16'h0000, 16'h0000, 28'h0008000}, 1'b1, QUIET},
    '{'{FUNC_PLAY, 12'h000, 16'h0000, 16'h0000, 28'h0000000}, 1'b0, QUIET},
    '{'{FUNC_SET, 12'h000, 16'h0000, 16'h0000, 28'hFFF0000}, 1'b1, QUIET},
    '{'{FUNC_PLAY, 12'h000, 16'h0000, 16'h0000, 28'h0000000}, 1'b1,
      '{16'hFFFF, 16'h0001, 1'b0, 1'b0}},
    '{'{FUNC_PLAY, 12'h000, 16'h0000, 16'h0000, 28'h0000000}, 1'b1, ENDED},
    '{'{FUNC_SET, 12'h000, 16'h0000, 16'h0000, 28'hFFF0001}, 1'b1, QUIET},
    '{'{FUNC_PLAY, 12'h000, 16'h0000, 16'h0000, 28'h0000000}, 1'b1, ENDED},
    '{'{FUNC_SET, 12'h000, 16'h0000, 16'h0000, 28'h000FFFF}, 1'b1, QUIET},
    '{'{FUNC_PLAY, 12'h000, 16'h0000, 16'h0000, 28'h0000000}, 1'b0, QUIET},
    '{'{FUNC_SET, 12'h000, 16'h0000, 16'h0000, 28'h0004000}, 1'b1, QUIET},
    '{'{FUNC_PLAY, 12'h000, 16'h0000, 16'h0000, 28'h0000000}, 1'b0, QUIET},
    '{'{FUNC_SET, 12'h000, 16'h0000, 16'h0000, 28'hFFFFFFF}, 1'b1, QUIET},
    '{'{FUNC_PLAY, 12'h000, 16'h0000, 16'h0000, 28'h0000000}, 1'b1, ENDED},
    '{'{FUNC_UNUSED, 12'h000, 16'h0000, 16'h0000, 28'h0000000}, 1'b1, QUIET}
  };

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  in_word_t                  in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_word_t                 out_data;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  logic [SAMPLE_BITS-1:0] frame_left [FRAME_SLOTS];
  logic [SAMPLE_BITS-1:0] frame_right [FRAME_SLOTS];
  bit                     frame_loaded [FRAME_SLOTS];
  logic [POS_BITS-1:0]    voice_pos = '0;
  bit                     release_seen = 1'b0;
  logic [SPEED_BITS-1:0]  voice_speed = SPEED_RESET;
  bit                     voice_looping = 1'b0;
  bit                     voice_one_shot = 1'b0;
  logic [COUNT_BITS-1:0]  voice_frames = FRAME_COUNT_RESET;

  out_word_t predicted_frames_q [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        words_out = 0;
  int        burst_left = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  int        stall_mode = 0;

  stereo_sample_playback_resampler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned frames_in_use();
    if (voice_frames == 0) return 1;
    if (voice_frames > FRAME_SLOTS) return FRAME_SLOTS;
    return voice_frames;
  endfunction

  // A play word reads nothing once a non-looping position, rounded up, reaches the frame count.
  function automatic bit play_reads(output int fa, output int fb);
    longint unsigned fc, span, pos;
    fc = frames_in_use();
    span = fc << FRACTION_BITS;
    pos = voice_pos;
    fa = 0;
    fb = 0;
    if (voice_looping) pos = pos % span;
    else if (pos + FIX_ONE - 1 >= span) return 1'b0;
    fa = int'(pos >> FRACTION_BITS);
    fb = (fa + 1 >= fc) ? 0 : fa + 1;
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] lerp(input logic [SAMPLE_BITS-1:0] a,
                                                  input logic [SAMPLE_BITS-1:0] b,
                                                  input longint unsigned t);
    longint unsigned oa, ob, acc;
    oa = a ^ SAMPLE_BIAS;
    ob = b ^ SAMPLE_BIAS;
    acc = (FIX_ONE - t) * oa + t * ob + (FIX_ONE >> 1);
    return SAMPLE_BITS'((acc >> FRACTION_BITS) - SAMPLE_BIAS);
  endfunction

  function automatic out_word_t voice_step(input in_word_t w);
    out_word_t res;
    longint unsigned span, t, np;
    int fa, fb;
    res = '0;
    case (w.func)
      FUNC_LOAD: begin
        frame_left[w.frame_addr] = w.left_in;
        frame_right[w.frame_addr] = w.right_in;
        frame_loaded[w.frame_addr] = 1'b1;
      end
      FUNC_SET: voice_pos = w.new_position;
      FUNC_PLAY: begin
        span = frames_in_use() << FRACTION_BITS;
        if (!play_reads(fa, fb)) begin
          res.ended = 1'b1;
          if (voice_one_shot && !release_seen) begin
            res.released = 1'b1;
            release_seen = 1'b1;
          end
        end else begin
          t = voice_pos[FRACTION_BITS-1:0];
          res.left_out = lerp(frame_left[fa], frame_left[fb], t);
          res.right_out = lerp(frame_right[fa], frame_right[fb], t);
          if (voice_looping) begin
            voice_pos = POS_BITS'((voice_pos + voice_speed) % span);
          end else begin
            np = voice_pos + voice_speed;
            voice_pos = (np > POS_MAX) ? POS_BITS'(POS_MAX) : POS_BITS'(np);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_word_t random_word();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_word_t)-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic offer_word(input in_word_t w, input out_word_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted_frames_q.push_back(want);
  endtask

  task automatic issue(input in_word_t w);
    out_word_t want;
    want = voice_step(w);
    offer_word(w, want);
  endtask

  task automatic load_frame(input int addr);
    in_word_t w;
    w = random_word();
    w.func = FUNC_LOAD;
    w.frame_addr = INDEX_BITS'(addr);
    issue(w);
  endtask

  task automatic settle_voice();
    in_valid <= 1'b0;
    burst_left = 0;
    while (predicted_frames_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_voice(input logic [SPEED_BITS-1:0] spd, input bit lp,
                               input bit os, input logic [COUNT_BITS-1:0] fc);
    write_reg(CFG_SPEED, CFG_DATA_BITS'(spd));
    write_reg(CFG_LOOPING, CFG_DATA_BITS'(lp));
    write_reg(CFG_ONE_SHOT, CFG_DATA_BITS'(os));
    write_reg(CFG_FRAME_COUNT, CFG_DATA_BITS'(fc));
    cfg_we <= 1'b0;
    voice_speed = spd;
    voice_looping = lp;
    voice_one_shot = os;
    voice_frames = fc;
  endtask

  // Play words make up most of a phase; frames that a play word would read are
  // loaded just before it, so no unwritten frame is ever read.
  task automatic run_phase(input int n_words);
    in_word_t w;
    int sent, fa, fb, pick;
    longint unsigned span, p;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(0, 99);
      w = random_word();
      span = frames_in_use() << FRACTION_BITS;
      if (pick < 60) begin
        if (play_reads(fa, fb)) begin
          if (!frame_loaded[fa]) begin
            load_frame(fa);
            sent++;
          end
          if (!frame_loaded[fb]) begin
            load_frame(fb);
            sent++;
          end
        end
        w.func = FUNC_PLAY;
        issue(w);
        sent++;
      end else if (pick < 75) begin
        case ($urandom_range(0, 4))
          0: p = w.new_position;
          1: p = $urandom % span;
          2: p = span - FIX_ONE + $urandom_range(0, 1);
          3: p = span - $urandom_range(1, FIX_ONE);
          default: p = span + $urandom_range(0, 4 * FIX_ONE);
        endcase
        w.func = FUNC_SET;
        w.new_position = p[POS_BITS-1:0];
        issue(w);
        sent++;
      end else if (pick < 90) begin
        w.func = FUNC_LOAD;
        if ($urandom_range(0, 1)) w.frame_addr = INDEX_BITS'($urandom % frames_in_use());
        issue(w);
        sent++;
      end else begin
        w.func = FUNC_UNUSED;
        issue(w);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("stereo_sample_playback_resampler verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && words_out >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (cycle_count % 97 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= (cycle_count % 4 != 0);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      words_out <= words_out + 1;
      if (predicted_frames_q.size() == 0) begin
        report_mismatch("result word with nothing predicted");
      end else begin
        want = predicted_frames_q.pop_front();
        if (out_data.left_out !== want.left_out)
          report_mismatch($sformatf("left_out %0d, predicted %0d",
                                    out_data.left_out, want.left_out));
        if (out_data.right_out !== want.right_out)
          report_mismatch($sformatf("right_out %0d, predicted %0d",
                                    out_data.right_out, want.right_out));
        if (out_data.ended !== want.ended)
          report_mismatch($sformatf("ended %b, predicted %b", out_data.ended, want.ended));
        if (out_data.released !== want.released)
          report_mismatch($sformatf("released %b, predicted %b",
                                    out_data.released, want.released));
      end
    end
  end

  initial begin
    out_word_t predicted;
    logic [SPEED_BITS-1:0] spd;
    logic [COUNT_BITS-1:0] fc;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(CUE_TABLE); i++) begin
      predicted = voice_step(CUE_TABLE[i].word);
      offer_word(CUE_TABLE[i].word, CUE_TABLE[i].typed ? CUE_TABLE[i].result : predicted);
    end
    settle_voice();

    for (int ph = 0; ph < PHASES; ph++) begin
      spd = ($urandom_range(0, 1) != 0) ? SPEED_BITS'($urandom) :
                                          SPEED_BITS'($urandom_range(0, 'h30000));
      case ($urandom_range(0, 3))
        0: fc = COUNT_BITS'($urandom_range(1, 8));
        1: fc = COUNT_BITS'($urandom_range(1, FRAME_SLOTS));
        2: fc = COUNT_BITS'($urandom_range(FRAME_SLOTS + 1, 8191));
        default: fc = '0;
      endcase
      case (ph)
        0: program_voice(24'hFFFFFF, 1'b0, 1'b1, 13'd1);
        1: program_voice(24'h000000, 1'b1, 1'b0, 13'd4096);
        2: program_voice(24'h010000, 1'b0, 1'b0, 13'd0);
        3: program_voice(24'hFFFFFF, 1'b1, 1'b1, 13'h1FFF);
        4: program_voice(24'hFFFFFF, 1'b0, 1'b0, 13'd4096);
        default: program_voice(spd, $urandom_range(0, 1), $urandom_range(0, 1), fc);
      endcase
      run_phase(PHASE_WORDS);
      settle_voice();
    end

    if (mismatches == 0) $display("stereo_sample_playback_resampler verification clean");
    else $display("stereo_sample_playback_resampler verification failed");
    $finish;
  end

endmodule

FILE: stereo_sample_playback_resampler.f
hw/rtl/ssr_pkg.sv
hw/rtl/ssr_ram.sv
hw/rtl/ssr_mod.sv
hw/rtl/ssr_datapath.sv
hw/rtl/ssr_ctrl.sv
hw/rtl/stereo_sample_playback_resampler.sv
tb/sv/tb_top.sv
